/* rtl/sdm_pkg.sv */
package sdm_pkg;

    // Fixed widths and constants of the magic number method.
    localparam int WordBits  = 32;
    localparam int ShiftBits = 5;
    localparam int PBits     = 6;
    localparam logic [WordBits-1:0] TwoPow31 = 32'h8000_0000;
    localparam logic [PBits-1:0]    BaseP    = 6'd31;
    localparam logic [PBits-1:0]    PLimit   = 6'd63;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SETUP  = 6'b000010,
        ST_INIT   = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_SAVE   = 6'b010000,
        ST_LOOP   = 6'b100000
    } sdm_state_t;

    // Which of the three divisions the shared divider is running.
    typedef enum logic [1:0] {
        SEL_MOD = 2'd0,
        SEL_Q1  = 2'd1,
        SEL_Q2  = 2'd2
    } sdm_div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         load;
        logic         div_init;
        logic         div_step;
        logic         div_save;
        sdm_div_sel_t sel;
        logic         iter;
        logic         out_load;
    } sdm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic unsup;
        logic loop_done;
        logic out_free;
    } sdm_status_t;

endpackage

/* rtl/sdm_if.sv */
// Request channel: one signed divisor per request.
interface sdm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

// Result channel: magic multiplier, shift count and the unsupported flag.
interface sdm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] multiplier;
    logic [4:0]         shift_count;
    logic               unsupported;

    modport source (output valid, output multiplier, output shift_count,
                    output unsupported, input ready);
    modport sink   (input valid, input multiplier, input shift_count,
                    input unsupported, output ready);
endinterface

/* rtl/sdm_ctrl.sv */
module sdm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdm_pkg::sdm_status_t status,
    output sdm_pkg::sdm_cmd_t    cmd
);
    import sdm_pkg::*;

    localparam logic [ShiftBits-1:0] DivLast = ShiftBits'(WordBits - 1);

    sdm_state_t             state_reg, state_next;
    sdm_div_sel_t           sel_reg, sel_next;
    logic [ShiftBits-1:0]   cnt_reg, cnt_next;

    // State, division select and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_MOD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                sel_next = SEL_MOD;
                if (!status.unsup)
                begin
                    state_next = ST_INIT;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DivLast)
                begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE:
            begin
                cmd.div_save = 1'b1;
                case (sel_reg)
                    SEL_MOD:
                    begin
                        sel_next   = SEL_Q1;
                        state_next = ST_INIT;
                    end
                    SEL_Q1:
                    begin
                        sel_next   = SEL_Q2;
                        state_next = ST_INIT;
                    end
                    default:
                    begin
                        state_next = ST_LOOP;
                    end
                endcase
            end
            ST_LOOP:
            begin
                // Double and reduce until delta is met or p reaches its limit, then hand off the result.
                if (!status.loop_done)
                begin
                    cmd.iter = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sdm_datapath.sv */
module sdm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [31:0]   divisor,
    input  sdm_pkg::sdm_cmd_t    cmd,
    output sdm_pkg::sdm_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   multiplier,
    output logic [4:0]           shift_count,
    output logic                 unsupported
);
    import sdm_pkg::*;

    logic                 neg_reg;
    logic [WordBits-1:0]  ad_reg;
    logic                 unsup_reg;
    logic [WordBits-1:0]  anc_reg;
    logic [WordBits-1:0]  q1_reg, r1_reg, q2_reg, r2_reg;
    logic [PBits-1:0]     p_reg;
    logic                 done_reg;

    logic [WordBits-1:0]  n_reg, d_reg, rem_reg, quo_reg;

    logic                 out_valid_reg;
    logic signed [31:0]   mult_reg;
    logic [4:0]           shift_reg;
    logic                 unsup_out_reg;

    logic [WordBits-1:0]  du;
    logic [WordBits-1:0]  ad_in;
    logic [WordBits-1:0]  t_val;
    logic [WordBits:0]    trial;
    logic                 trial_ge;
    logic [WordBits-1:0]  q1_next, r1_next, q2_next, r2_next;
    logic [WordBits-1:0]  delta;
    logic [PBits-1:0]     p_next;
    logic                 keep_going;
    logic [WordBits-1:0]  m_pos;
    logic                 out_free;

    // Magnitude of the incoming divisor.
    assign du    = divisor;
    assign ad_in = du[WordBits-1] ? (~du + 1'b1) : du;
    assign t_val = TwoPow31 | {{(WordBits-1){1'b0}}, neg_reg};

    // One restoring division step.
    assign trial    = {rem_reg, n_reg[WordBits-1]};
    assign trial_ge = (trial >= {1'b0, d_reg});

    // One doubling iteration on both quotient and remainder pairs.
    always_comb
    begin
        q1_next = {q1_reg[WordBits-2:0], 1'b0};
        r1_next = {r1_reg[WordBits-2:0], 1'b0};
        if (r1_next >= anc_reg)
        begin
            q1_next = q1_next + 1'b1;
            r1_next = r1_next - anc_reg;
        end
        q2_next = {q2_reg[WordBits-2:0], 1'b0};
        r2_next = {r2_reg[WordBits-2:0], 1'b0};
        if (r2_next >= ad_reg)
        begin
            q2_next = q2_next + 1'b1;
            r2_next = r2_next - ad_reg;
        end
        delta      = ad_reg - r2_next;
        p_next     = p_reg + 1'b1;
        keep_going = (q1_next < delta) || ((q1_next == delta) && (r1_next == '0));
    end

    // Captured divisor and the working registers of the method.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg   <= du[WordBits-1];
            ad_reg    <= ad_in;
            unsup_reg <= (ad_in < 32'd2);
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            case (cmd.sel)
                SEL_MOD:
                begin
                    n_reg <= t_val;
                    d_reg <= ad_reg;
                end
                SEL_Q1:
                begin
                    n_reg <= TwoPow31;
                    d_reg <= anc_reg;
                end
                default:
                begin
                    n_reg <= TwoPow31;
                    d_reg <= ad_reg;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            n_reg   <= {n_reg[WordBits-2:0], 1'b0};
            quo_reg <= {quo_reg[WordBits-2:0], trial_ge};
            rem_reg <= trial_ge ? WordBits'(trial - {1'b0, d_reg})
                                : trial[WordBits-1:0];
        end
        if (cmd.div_save)
        begin
            case (cmd.sel)
                SEL_MOD:
                begin
                    anc_reg <= t_val - 1'b1 - rem_reg;
                end
                SEL_Q1:
                begin
                    q1_reg <= quo_reg;
                    r1_reg <= rem_reg;
                end
                default:
                begin
                    q2_reg <= quo_reg;
                    r2_reg <= rem_reg;
                    p_reg  <= BaseP;
                end
            endcase
        end
        else if (cmd.iter)
        begin
            q1_reg <= q1_next;
            r1_reg <= r1_next;
            q2_reg <= q2_next;
            r2_reg <= r2_next;
            p_reg  <= p_next;
        end
    end

    // Loop exit flag, cleared whenever a division result is stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (cmd.div_save)
        begin
            done_reg <= 1'b0;
        end
        else if (cmd.iter)
        begin
            done_reg <= !keep_going || (p_next >= PLimit);
        end
    end

    // Result register; it frees the worker side while a result waits.
    assign out_free = !out_valid_reg || out_ready;
    assign m_pos    = q2_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unsup_out_reg <= unsup_reg;
            if (unsup_reg)
            begin
                mult_reg  <= '0;
                shift_reg <= '0;
            end
            else
            begin
                mult_reg  <= neg_reg ? (~m_pos + 1'b1) : m_pos;
                shift_reg <= p_reg[ShiftBits-1:0];
            end
        end
    end

    assign status.unsup     = unsup_reg;
    assign status.loop_done = done_reg;
    assign status.out_free  = out_free;

    assign out_valid   = out_valid_reg;
    assign multiplier  = mult_reg;
    assign shift_count = shift_reg;
    assign unsupported = unsup_out_reg;

endmodule

/* rtl/signed_div_magic_number.sv */
// Channel  Modport  Fields                                      Role
// req      sink     divisor[31:0] signed                        divisor request
// rsp      source   multiplier[31:0] signed, shift_count[4:0],  magic number result
//                   unsupported
//
// One request at a time; a supported divisor's result can first be taken after
// setup, three divisions on one shared divider, k = 1 to 32 doubling iterations,
// result load and hand-over. Divisors -1, 0 and 1 skip the divisions and the loop;
// their result is loaded straight from setup. A held result lets the next request
// in; a later result stalls in the controller until the output register is free.
// rst_n is asynchronous and active low and clears the controller and valid flags.
module signed_div_magic_number (
    input  logic     clk,
    input  logic     rst_n,
    sdm_in_if.sink   req,
    sdm_out_if.source rsp
);
    import sdm_pkg::*;

    sdm_cmd_t    cmd;
    sdm_status_t status;

    // Sequencer for the divisions and the doubling loop.
    sdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Divider, doubling unit and result register.
    sdm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (req.divisor),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .multiplier  (rsp.multiplier),
        .shift_count (rsp.shift_count),
        .unsupported (rsp.unsupported)
    );

endmodule

/* rtl/sdm_checker.sv */
module sdm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] multiplier,
    input logic [4:0]         shift_count,
    input logic               unsupported
);

    // A held result keeps its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(multiplier)
            && $stable(shift_count) && $stable(unsupported))
        else $error("result changed while stalled");

    // An unsupported divisor returns all zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unsupported |-> multiplier == 0 && shift_count == 0)
        else $error("unsupported result not zero");

    // Only one request is in work: the request side closes after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // No result appears in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result too early after request");

endmodule

bind signed_div_magic_number sdm_checker u_sdm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .multiplier  (rsp.multiplier),
    .shift_count (rsp.shift_count),
    .unsupported (rsp.unsupported)
);

/* verif/signed_div_magic_number_tb.sv */
`timescale 1ns / 100ps

module signed_div_magic_number_tb;

    localparam logic [31:0] TwoPow31       = 32'h8000_0000;
    localparam int          GapPercent     = 17;
    localparam int          RandomDivisors = 500;
    // Settle time leaves room beyond the slowest supported divisor.
    localparam int          SettleCycles   = 200;

    // Divisors that sit on the edges of the method.
    localparam logic [31:0] CornerDivisors [22] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFE, 32'h0000_0003,
        32'hFFFF_FFFD, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007,
        32'hFFFF_FFF9, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001,
        32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0281, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_0019
    };

    typedef struct packed {
        logic signed [31:0] multiplier;
        logic [4:0]         shift_count;
        logic               unsupported;
    } magic_t;

    logic   clk;
    logic   rst_n;
    logic   steady;
    int     error_count;
    magic_t pending_magic [$];

    sdm_in_if  req ();
    sdm_out_if rsp ();

    signed_div_magic_number dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Magic multiplier and shift for a signed divisor, from |d| and |nc|.
    function automatic magic_t magic_for_divisor(input logic [31:0] d);
        logic        neg;
        logic        done;
        logic [31:0] mag;
        logic [31:0] t;
        logic [31:0] anc;
        logic [31:0] q1;
        logic [31:0] r1;
        logic [31:0] q2;
        logic [31:0] r2;
        logic [31:0] delta;
        logic [31:0] m;
        int unsigned p;
        magic_t      res;
        res = '0;
        neg = d[31];
        mag = neg ? 32'd0 - d : d;
        if (mag < 32'd2)
        begin
            res.unsupported = 1'b1;
            return res;
        end
        t   = TwoPow31 + {31'd0, d[31]};
        anc = t - 32'd1 - (t % mag);
        p   = 31;
        q1  = TwoPow31 / anc;
        r1  = TwoPow31 - q1 * anc;
        q2  = TwoPow31 / mag;
        r2  = TwoPow31 - q2 * mag;
        done = 1'b0;
        // Double both quotient and remainder pairs until delta is met or p reaches 63.
        while (!done)
        begin
            p++;
            q1 = q1 << 1;
            r1 = r1 << 1;
            if (r1 >= anc)
            begin
                q1 = q1 + 32'd1;
                r1 = r1 - anc;
            end
            q2 = q2 << 1;
            r2 = r2 << 1;
            if (r2 >= mag)
            begin
                q2 = q2 + 32'd1;
                r2 = r2 - mag;
            end
            delta = mag - r2;
            if (!(q1 < delta || (q1 == delta && r1 == 32'd0)))
                done = 1'b1;
            else if (p >= 63)
                done = 1'b1;
        end
        m = q2 + 32'd1;
        if (neg)
            m = 32'd0 - m;
        res.multiplier  = m;
        res.shift_count = 5'(p - 32);
        return res;
    endfunction

    // Random divisor, weighted toward small magnitudes and powers of two.
    function automatic logic [31:0] pick_divisor();
        logic [31:0] mag;
        case ($urandom_range(9))
            0: mag = $urandom_range(3);
            1: mag = 32'd1 << $urandom_range(31);
            2: mag = (32'd1 << $urandom_range(31)) + $urandom_range(2) - 32'd1;
            3: mag = $urandom_range(1000);
            default: return $urandom();
        endcase
        return $urandom_range(1) ? 32'd0 - mag : mag;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Sends one divisor request; called and returns at a falling edge.
    task automatic send_divisor(input logic [31:0] d);
        while (!steady && $urandom_range(99) < GapPercent)
        begin
            req.valid   <= 1'b0;
            req.divisor <= $urandom();
            @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.divisor <= d;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_magic.insert(pending_magic.size(), magic_for_divisor(d));
        @(negedge clk);
    endtask

    // Holds off new requests until every pending result has come back.
    task automatic wait_until_drained();
        req.valid <= 1'b0;
        while (pending_magic.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic test_corner_divisors();
        foreach (CornerDivisors[i])
            send_divisor(CornerDivisors[i]);
    endtask

    task automatic test_pause_until_drained();
        repeat (4)
            send_divisor(pick_divisor());
        wait_until_drained();
        repeat (4)
            send_divisor(pick_divisor());
        wait_until_drained();
    endtask

    task automatic test_random_divisors();
        for (int i = 0; i < RandomDivisors; i++)
        begin
            // A stretch in the middle runs with neither side idling.
            steady = (i >= 150 && i < 250);
            send_divisor(pick_divisor());
        end
        steady = 1'b0;
    endtask

    // Response ready with random stalls.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= steady || ($urandom_range(99) >= GapPercent);
        end
    end

    // Compare each result with the oldest pending expectation.
    always @(posedge clk)
    begin
        magic_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_magic.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = pending_magic.pop_front();
                if (rsp.multiplier !== want.multiplier)
                    report_mismatch($sformatf("multiplier got %h expected %h",
                                              rsp.multiplier, want.multiplier));
                if (rsp.shift_count !== want.shift_count)
                    report_mismatch($sformatf("shift_count got %0d expected %0d",
                                              rsp.shift_count, want.shift_count));
                if (rsp.unsupported !== want.unsupported)
                    report_mismatch($sformatf("unsupported got %b expected %b",
                                              rsp.unsupported, want.unsupported));
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.divisor = 32'd0;
        steady      = 1'b0;
        error_count = 0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_divisors();
        test_pause_until_drained();
        test_random_divisors();

        wait_until_drained();
        repeat (SettleCycles)
            @(negedge clk);
        if (error_count == 0)
            $display("signed_div_magic_number_tb OK");
        else
            $display("signed_div_magic_number_tb NOT OK");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("TIMEOUT at %0t ns", $time);
        $display("signed_div_magic_number_tb NOT OK");
        $finish;
    end

endmodule
